FILE: rtl/lesc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the expert slot cache.
// No dependencies; every other file imports this package.
package lesc_pkg;

  localparam int TAG_W      = 20;
  localparam int STAMP_W    = 64;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic CMD_DEMAND   = 1'b0;
  localparam logic CMD_PREFETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_FILL    = 3'd1,
    ST_EVICT   = 3'd2,
    ST_PRESENT = 3'd3,
    ST_REJECT  = 3'd4
  } status_t;

  typedef struct packed {
    logic       command;
    logic [7:0] layer_index;
    logic [1:0] weight_kind;
    logic [9:0] expert_number;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] slot_index;
    logic [7:0] evicted_layer;
    logic [1:0] evicted_kind;
    logic [9:0] evicted_expert;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } slot_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic scan_start;
    logic commit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic reject;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/lesc_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the expert slot cache: clear pass, scan, commit.
// Depends on lesc_pkg for the command and status structs.
module lesc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lesc_pkg::dp_sts_t  sts,
  output lesc_pkg::ctrl_cmd_t cmd
);
  import lesc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_START  = 5'b00100,
    S_WAIT   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        // rejected requests skip the scan
        if (sts.reject) begin
          state_next = S_COMMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/lesc_dp.sv
`timescale 1ns / 1ps
// Datapath for the expert slot cache: slot memory, scan trackers, use counter,
// configuration registers and output register. Depends on lesc_pkg.
module lesc_dp #(
  parameter int N_SLOTS        = 64,
  parameter int N_WEIGHT_KINDS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lesc_pkg::ctrl_cmd_t                 cmd,
  output lesc_pkg::dp_sts_t                   sts,
  input  lesc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lesc_pkg::out_item_t                 out_data,
  input  logic                                cfg_write_en,
  input  logic [lesc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lesc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lesc_pkg::*;

  localparam int IDX_W = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
  localparam int CNT_W = $clog2(N_SLOTS + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  // configuration
  logic [6:0] slots_in_use;
  logic [8:0] layer_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= 7'd64;
      layer_count  <= 9'd256;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[6:0];
        CFG_LAYER_COUNT:  layer_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // active slot count, clamped to 1..N_SLOTS
  logic [CMP_W-1:0] siu_ext;
  logic [CNT_W-1:0] act_cnt;

  always_comb begin
    siu_ext = CMP_W'(slots_in_use);
    if (siu_ext == '0) begin
      act_cnt = CNT_W'(1);
    end else if (siu_ext > CMP_W'(N_SLOTS)) begin
      act_cnt = CNT_W'(N_SLOTS);
    end else begin
      act_cnt = CNT_W'(siu_ext);
    end
  end

  // request registers
  logic [TAG_W-1:0] req_tag;
  logic             req_cmd;
  logic             reject_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_tag  <= {in_data.layer_index, in_data.weight_kind, in_data.expert_number};
      req_cmd  <= in_data.command;
      reject_q <= ({1'b0, in_data.layer_index} >= layer_count) ||
                  (3'(in_data.weight_kind) >= 3'(N_WEIGHT_KINDS));
    end
  end

  // slot memory
  slot_entry_t mem [N_SLOTS];
  slot_entry_t mem_q;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_entry_t mem_wdata;

  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] clr_addr;
  logic             scan_busy;
  logic             scan_last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[scan_addr];
  end

  // clear pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // read sequencer
  logic             data_vld;
  logic             data_last;
  logic [IDX_W-1:0] data_idx;

  assign scan_last = (CNT_W'(scan_addr) == act_cnt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      data_vld  <= 1'b0;
    end else begin
      data_vld <= scan_busy;
      if (cmd.scan_start) begin
        scan_busy <= 1'b1;
      end else if (scan_busy && scan_last) begin
        scan_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_idx  <= scan_addr;
    data_last <= scan_last;
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (scan_busy) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
  end

  // scan trackers
  logic               scan_done;
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic               empty_found;
  logic [IDX_W-1:0]   empty_idx;
  logic               min_init;
  logic [STAMP_W-1:0] min_stamp;
  logic [IDX_W-1:0]   min_idx;
  logic [TAG_W-1:0]   min_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_done <= 1'b0;
    end else if (data_vld && data_last) begin
      scan_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      min_init    <= 1'b0;
    end else if (data_vld) begin
      // lowest matching index wins
      if (mem_q.valid && mem_q.tag == req_tag && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= data_idx;
      end
      if (!mem_q.valid && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= data_idx;
      end
      // strict compare keeps the lowest index on a tie
      if (!min_init || mem_q.stamp < min_stamp) begin
        min_init  <= 1'b1;
        min_stamp <= mem_q.stamp;
        min_idx   <= data_idx;
        min_tag   <= mem_q.tag;
      end
    end
  end

  // commit decision
  logic [STAMP_W-1:0] use_counter;
  logic [STAMP_W-1:0] cnt_inc;
  logic               commit_wr;
  logic [IDX_W-1:0]   commit_addr;
  out_item_t          result;

  assign cnt_inc = use_counter + STAMP_W'(1);

  always_comb begin
    result      = '0;
    commit_wr   = 1'b0;
    commit_addr = min_idx;
    if (reject_q) begin
      result.status = ST_REJECT;
    end else if (hit_found) begin
      result.slot_index = 6'(hit_idx);
      commit_addr       = hit_idx;
      if (req_cmd == CMD_DEMAND) begin
        result.status = ST_HIT;
        commit_wr     = 1'b1;
      end else begin
        result.status = ST_PRESENT;
      end
    end else if (empty_found) begin
      result.status     = ST_FILL;
      result.slot_index = 6'(empty_idx);
      commit_addr       = empty_idx;
      commit_wr         = 1'b1;
    end else begin
      result.status         = ST_EVICT;
      result.slot_index     = 6'(min_idx);
      result.evicted_layer  = min_tag[19:12];
      result.evicted_kind   = min_tag[11:10];
      result.evicted_expert = min_tag[9:0];
      commit_wr             = 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = commit_addr;
    mem_wdata = '{valid: 1'b1, tag: req_tag, stamp: cnt_inc};
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (cmd.commit && commit_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_counter <= '0;
    end else if (cmd.commit && commit_wr) begin
      use_counter <= cnt_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= result;
    end
  end

  always_comb begin
    sts.clear_last = (clr_addr == IDX_W'(N_SLOTS - 1));
    sts.reject     = reject_q;
    sts.scan_done  = scan_done;
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule

FILE: rtl/lru_expert_slot_cache.sv
`timescale 1ns / 1ps
// Expert slot cache top level: fully associative, timestamp LRU replacement.
// Each accepted request scans the n active slots (n = active slot count) one entry
// per cycle through the slot memory read port; a reject skips the scan.
// One request at a time: input stalls until its result is committed; a waiting result
// does not block input.
// Reset: synchronous; a clearing pass over all N_SLOTS slots follows, input stalled.
module lru_expert_slot_cache #(
  parameter int N_SLOTS        = 64,
  parameter int N_WEIGHT_KINDS = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lesc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lesc_pkg::out_item_t             out_data,
  input  logic                            cfg_write_en,
  input  logic [lesc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lesc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lesc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lesc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lesc_dp #(
    .N_SLOTS        (N_SLOTS),
    .N_WEIGHT_KINDS (N_WEIGHT_KINDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

FILE: rtl/lesc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the expert slot cache, bound to the top level.
// Depends on lesc_pkg and lru_expert_slot_cache.
module lesc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lesc_pkg::out_item_t out_data
);
  import lesc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // the clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input taken during clearing pass");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_REJECT |->
      out_data.slot_index == 6'd0 && out_data.evicted_layer == 8'd0 &&
      out_data.evicted_kind == 2'd0 && out_data.evicted_expert == 10'd0)
    else $error("rejected beat carries nonzero fields");

  a_evict_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_EVICT |->
      out_data.evicted_layer == 8'd0 && out_data.evicted_kind == 2'd0 &&
      out_data.evicted_expert == 10'd0)
    else $error("evicted tag reported without eviction");

endmodule

bind lru_expert_slot_cache lesc_checker u_lesc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
